FILE: hdl/line_sensor_calibrate_threshold_unit_assert.svh
// Assertion macros shared by the checker of the line sensor threshold unit.
// No dependencies; the files that assert take this header by include.
`ifndef LINE_SENSOR_CALIBRATE_THRESHOLD_UNIT_ASSERT_SVH
`define LINE_SENSOR_CALIBRATE_THRESHOLD_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSCT_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lsct assertion failed (same cycle)");

// The consequent must hold in the cycle after the antecedent.
`define LSCT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lsct assertion failed (next cycle)");

// Delayed form: the consequent must hold after the antecedent.
`define LSCT_ASSERT_DELAY2(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##2 (cons)) \
        else $error("lsct assertion failed (two cycles later)");

`endif

FILE: hdl/lsct_pkg.sv
// Package of the line sensor threshold unit: field widths, default parameters,
// transaction kind codes and the request type of the shared arithmetic unit.
// No dependencies.
package lsct_pkg;

    localparam int DEF_NUM_SENSORS = 32;
    localparam int DEF_SAMPLE_BITS = 12;

    localparam int KIND_W      = 2;
    localparam int IDX_FIELD_W = 5;
    localparam int READING_W   = 12;
    localparam int MASK_W      = 32;
    // Wide enough to compare a sensor index against a sensor count of up to 64.
    localparam int IDX_EXT_W   = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_BEGIN  = 2'd0,
        KIND_CAL    = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_DETECT = 2'd3
    } kind_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
    } alu_req_t;

endpackage

FILE: hdl/lsct_alu.sv
// Shared add/compare unit of the line sensor threshold unit.
// Depends on lsct_pkg for the request type.
module lsct_alu import lsct_pkg::*; #(
    parameter int DATA_W = DEF_SAMPLE_BITS
) (
    input  alu_req_t          req,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic [DATA_W:0]   sum,
    output logic              lt
);

    logic [DATA_W:0] b_ext;
    logic            sub;

    // One adder serves both jobs: a + b, or a - b whose sign bit gives a < b.
    assign sub   = (req.op == ALU_SUB);
    assign b_ext = sub ? ~{1'b0, b} : {1'b0, b};
    assign sum   = {1'b0, a} + b_ext + {{DATA_W{1'b0}}, sub};
    assign lt    = sub & sum[DATA_W];

endmodule

FILE: hdl/line_sensor_calibrate_threshold_unit.sv
// Line sensor calibration and threshold detection unit: per-sensor min, max and
// threshold stores, a line mask built over one scan. Depends on lsct_pkg, lsct_alu.
//
// Steps: begin calibration and a sample for a sensor outside the array need only the
// idle step, a detect sample a compare step, a calibration sample a max and a min step,
// and finish calibration a read and an add step per sensor; all compares and adds use
// the one shared adder/comparator, and all reads the single read port of each store.
// The mask transaction is registered once the last sensor's detect sample is evaluated
// and the output register is free, and waits in it. Reset (aresetn low, synchronous) clears
// the sequencer, the output valid, the mask to all ones and the store valid bits.
module line_sensor_calibrate_threshold_unit import lsct_pkg::*; #(
    parameter int NUM_SENSORS = DEF_NUM_SENSORS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [KIND_W-1:0]      s_kind,
    input  logic [IDX_FIELD_W-1:0] s_sensor_index,
    input  logic [READING_W-1:0]   s_reading,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [MASK_W-1:0]      m_line_mask
);

    localparam int IDX_W = $clog2(NUM_SENSORS);
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
    localparam logic [SAMPLE_BITS-1:0] HALF_SCALE = FULL_SCALE >> 1;
    localparam logic [IDX_EXT_W-1:0]   NUM_EXT    = IDX_EXT_W'(NUM_SENSORS);
    localparam logic [IDX_EXT_W-1:0]   LAST_EXT   = IDX_EXT_W'(NUM_SENSORS - 1);
    localparam logic [IDX_W-1:0]       LAST_ADDR  = IDX_W'(NUM_SENSORS - 1);

    // The sequencer walks through these steps; only the idle step takes a transaction.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAL_MAX,
        ST_CAL_MIN,
        ST_DET,
        ST_FIN_RD,
        ST_FIN_ADD
    } state_t;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         addr_reg, addr_next;
    logic [IDX_FIELD_W-1:0]   idx_reg, idx_next;
    logic [SAMPLE_BITS-1:0]   rd_reg, rd_next;
    logic                     last_reg, last_next;
    logic [MASK_W-1:0]        mask_reg, mask_next;
    logic                     m_valid_reg, m_valid_next;
    logic [MASK_W-1:0]        m_mask_reg, m_mask_next;
    logic [NUM_SENSORS-1:0]   cal_valid_reg, cal_valid_next;
    logic [NUM_SENSORS-1:0]   thr_valid_reg, thr_valid_next;

    // The three stores. Each has one write port and one registered read port, all
    // reading at the same address. An entry whose valid bit is clear reads as its
    // reset value, so begin calibration clears the min/max stores by clearing their valid bits.
    logic [SAMPLE_BITS-1:0] max_mem [NUM_SENSORS];
    logic [SAMPLE_BITS-1:0] min_mem [NUM_SENSORS];
    logic [SAMPLE_BITS-1:0] thr_mem [NUM_SENSORS];
    logic [SAMPLE_BITS-1:0] max_rdata_reg, min_rdata_reg, thr_rdata_reg;

    logic [IDX_W-1:0]       rd_addr;
    logic                   max_we, min_we, thr_we;
    logic [SAMPLE_BITS-1:0] max_wdata, min_wdata, thr_wdata;

    logic [IDX_EXT_W-1:0]   s_idx_ext;
    logic [IDX_W-1:0]       s_addr;
    logic                   s_in_range;
    logic [27:0]            s_reading_wide;
    logic                   accept;
    logic                   out_free;

    logic [SAMPLE_BITS-1:0] max_eff, min_eff, thr_eff;
    logic [MASK_W-1:0]      mask_clr;

    alu_req_t               alu_req;
    logic [SAMPLE_BITS-1:0] alu_a, alu_b;
    logic [SAMPLE_BITS:0]   alu_sum;
    logic                   alu_lt;

    assign s_ready  = (state_reg == ST_IDLE) && aresetn;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_line_mask = m_mask_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Only the low SAMPLE_BITS bits of a reading count; a wider sample zero-extends.
    assign s_reading_wide = {16'd0, s_reading};
    assign s_idx_ext      = {{(IDX_EXT_W - IDX_FIELD_W){1'b0}}, s_sensor_index};
    assign s_addr         = s_idx_ext[IDX_W-1:0];
    assign s_in_range     = (s_idx_ext < NUM_EXT);

    // In the idle step the stores are read at the incoming sensor, so the data is
    // ready in the next step; later steps keep reading at the latched address.
    assign rd_addr = (state_reg == ST_IDLE) ? s_addr : addr_reg;

    assign max_eff = cal_valid_reg[addr_reg] ? max_rdata_reg : '0;
    assign min_eff = cal_valid_reg[addr_reg] ? min_rdata_reg : FULL_SCALE;
    assign thr_eff = thr_valid_reg[addr_reg] ? thr_rdata_reg : HALF_SCALE;

    // Operand selection for the shared unit in each step.
    always_comb begin
        alu_req.op = ALU_SUB;
        alu_a      = rd_reg;
        alu_b      = thr_eff;
        unique case (state_reg)
            ST_CAL_MAX: begin
                alu_a = max_eff;
                alu_b = rd_reg;
            end
            ST_CAL_MIN: begin
                alu_a = rd_reg;
                alu_b = min_eff;
            end
            ST_FIN_RD, ST_FIN_ADD: begin
                alu_req.op = ALU_ADD;
                alu_a      = max_eff;
                alu_b      = min_eff;
            end
            default: begin
                alu_req.op = ALU_SUB;
            end
        endcase
    end

    lsct_alu #(
        .DATA_W (SAMPLE_BITS)
    ) u_alu (
        .req (alu_req),
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .lt  (alu_lt)
    );

    assign mask_clr = alu_lt ? (mask_reg & ~(MASK_W'(1) << idx_reg)) : mask_reg;

    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        idx_next       = idx_reg;
        rd_next        = rd_reg;
        last_next      = last_reg;
        mask_next      = mask_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_mask_next    = m_mask_reg;
        cal_valid_next = cal_valid_reg;
        thr_valid_next = thr_valid_reg;
        max_we         = 1'b0;
        min_we         = 1'b0;
        thr_we         = 1'b0;
        max_wdata      = alu_lt ? rd_reg : max_eff;
        min_wdata      = alu_lt ? rd_reg : min_eff;
        thr_wdata      = alu_sum[SAMPLE_BITS:1];

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    addr_next = s_addr;
                    idx_next  = s_sensor_index;
                    rd_next   = s_reading_wide[SAMPLE_BITS-1:0];
                    last_next = (s_idx_ext == LAST_EXT);
                    unique case (kind_t'(s_kind))
                        KIND_BEGIN: begin
                            cal_valid_next = '0;
                        end
                        KIND_FINISH: begin
                            addr_next  = '0;
                            state_next = ST_FIN_RD;
                        end
                        KIND_CAL: begin
                            if (s_in_range) begin
                                state_next = ST_CAL_MAX;
                            end
                        end
                        KIND_DETECT: begin
                            if (s_in_range) begin
                                state_next = ST_DET;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CAL_MAX: begin
                // Both entries are rewritten, so a sensor never holds half-fresh data.
                max_we     = 1'b1;
                state_next = ST_CAL_MIN;
            end
            ST_CAL_MIN: begin
                min_we                   = 1'b1;
                cal_valid_next[addr_reg] = 1'b1;
                state_next               = ST_IDLE;
            end
            ST_DET: begin
                if (last_reg) begin
                    // The last sensor closes the scan; wait here if the previous
                    // mask transaction has not been taken yet.
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_mask_next  = mask_clr;
                        mask_next    = '1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    mask_next  = mask_clr;
                    state_next = ST_IDLE;
                end
            end
            ST_FIN_RD: begin
                state_next = ST_FIN_ADD;
            end
            ST_FIN_ADD: begin
                thr_we                   = 1'b1;
                thr_valid_next[addr_reg] = 1'b1;
                if (addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end else begin
                    addr_next  = addr_reg + IDX_W'(1);
                    state_next = ST_FIN_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mask_reg      <= '1;
            m_valid_reg   <= 1'b0;
            cal_valid_reg <= '0;
            thr_valid_reg <= '0;
        end else begin
            state_reg     <= state_next;
            mask_reg      <= mask_next;
            m_valid_reg   <= m_valid_next;
            cal_valid_reg <= cal_valid_next;
            thr_valid_reg <= thr_valid_next;
        end
        addr_reg   <= addr_next;
        idx_reg    <= idx_next;
        rd_reg     <= rd_next;
        last_reg   <= last_next;
        m_mask_reg <= m_mask_next;
    end

    always_ff @(posedge aclk) begin
        if (max_we) begin
            max_mem[addr_reg] <= max_wdata;
        end
        if (min_we) begin
            min_mem[addr_reg] <= min_wdata;
        end
        if (thr_we) begin
            thr_mem[addr_reg] <= thr_wdata;
        end
        max_rdata_reg <= max_mem[rd_addr];
        min_rdata_reg <= min_mem[rd_addr];
        thr_rdata_reg <= thr_mem[rd_addr];
    end

endmodule

FILE: hdl/lsct_checker.sv
// Port-level checker of the line sensor threshold unit and its bind statement.
// Depends on lsct_pkg and line_sensor_calibrate_threshold_unit_assert.svh.
`include "line_sensor_calibrate_threshold_unit_assert.svh"

module lsct_checker import lsct_pkg::*; #(
    parameter int NUM_SENSORS = DEF_NUM_SENSORS
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic [KIND_W-1:0]      s_kind,
    input logic [IDX_FIELD_W-1:0] s_sensor_index,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [MASK_W-1:0]      m_line_mask
);

    localparam logic [IDX_EXT_W-1:0] LAST_EXT = IDX_EXT_W'(NUM_SENSORS - 1);

    logic                 s_accept;
    logic [IDX_EXT_W-1:0] idx_ext;
    logic                 emits;

    assign s_accept = s_valid && s_ready;
    assign idx_ext  = {{(IDX_EXT_W - IDX_FIELD_W){1'b0}}, s_sensor_index};
    // Only a detect sample of the last sensor may start a mask transaction.
    assign emits    = (s_kind == KIND_DETECT) && (idx_ext == LAST_EXT);

    // A waiting mask transaction holds its value.
    `LSCT_ASSERT_NEXT(a_mask_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_line_mask))
    // A transaction that cannot close a scan never raises the result valid.
    `LSCT_ASSERT_DELAY2(a_no_spurious_result, aclk, aresetn, s_accept && !emits, !$rose(m_valid))
    // Begin calibration completes in its own cycle.
    `LSCT_ASSERT_NEXT(a_begin_one_cycle, aclk, aresetn, s_accept && (s_kind == KIND_BEGIN), s_ready)
    // Finish calibration walks the stores, so the unit is busy afterwards.
    `LSCT_ASSERT_NEXT(a_finish_busy, aclk, aresetn, s_accept && (s_kind == KIND_FINISH), !s_ready)

endmodule

bind line_sensor_calibrate_threshold_unit lsct_checker #(
    .NUM_SENSORS (NUM_SENSORS)
) u_lsct_checker (.*);
